FILE: src/bsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bit-sliced index package
// Shared word width, operation codes and status codes.
// ----------------------------------------------------------------------------
package bsi_pkg;
    localparam int WORD_BITS = 64;

    typedef enum logic [2:0] {
        OP_APPEND  = 3'd0,
        OP_EQUAL   = 3'd1,
        OP_GREATER = 3'd2,
        OP_GEQ     = 3'd3,
        OP_NOTNULL = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NEG_KEY   = 3'd1,
        ST_KEY_RANGE = 3'd2,
        ST_NEG_VAL   = 3'd3,
        ST_VAL_RANGE = 3'd4
    } t_status;

    localparam logic CFG_MIN = 1'b0;
    localparam logic CFG_MAX = 1'b1;
endpackage
`default_nettype wire

FILE: src/bsi_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access a cycle, a write also reading the old word; registered read data.
// ----------------------------------------------------------------------------
module bsi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

FILE: src/bit_sliced_index_query.sv
`timescale 1ns / 1ps
`default_nettype none
// Append: the slices are stepped in order; a clear value bit is skipped and a set bit,
// then the existence word, gets a read-modify-write (written only on status OK).
// Query: each 64-row word is built from the existence word and then the slices, each
// read over the single memory port in S_RD and used in S_USE, then sent from S_OUT.
// Reset: synchronous active low; a clearing pass then walks the slice memory,
// one word a cycle, before the first request is taken.
// ----------------------------------------------------------------------------
// Bit-sliced index query
// Builds a bit-sliced index and streams query bitmaps, one slice digit a step.
// ----------------------------------------------------------------------------
module bit_sliced_index_query #(
    parameter int ROW_COUNT  = 1024,
    parameter int MAX_SLICES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [2:0] opcode, [34:3] row_key, [66:35] operand_value, zero fill to 72
    input  wire logic [71:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [63:0] row_bits, [67:64] word_index, [70:68] status, zero fill to 72
    output logic      [71:0] m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import bsi_pkg::*;

    localparam int WORDS  = (ROW_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SL     = MAX_SLICES + 1; // slot MAX_SLICES holds existence
    localparam int SW     = $clog2(SL + 1);
    localparam int DEPTH  = SL * WORDS;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNTW   = $clog2(DEPTH + 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RD    = 7'b0000100,
        S_USE   = 7'b0001000,
        S_OUT   = 7'b0010000,
        S_APPRD = 7'b0100000,
        S_APPWR = 7'b1000000
    } t_state;

    t_state r_state;
    logic [CNTW-1:0] r_clr;
    logic [15:0] r_min, r_max;
    t_opcode r_op;
    logic [31:0] r_code;
    logic [SW-1:0] r_slice;
    logic [WW-1:0] r_word;
    logic [5:0] r_bit;
    logic [63:0] r_acc;
    logic [63:0] r_exist;
    logic r_started;
    logic r_empty;
    logic [4:0] r_nsl;
    logic r_aok;
    logic [71:0] r_out;
    logic r_last, r_ovalid;

    logic [AW-1:0] w_addr;
    logic w_we;
    logic [63:0] w_wdata, w_rdata;

    bsi_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    // Decode of the request fields.
    logic [2:0] w_op;
    logic signed [31:0] w_key, w_val;
    assign w_op  = s_axis_tdata[2:0];
    assign w_key = s_axis_tdata[34:3];
    assign w_val = s_axis_tdata[66:35];

    // Slice count from the bit length of max_value.
    logic [4:0] w_nsl;
    always_comb begin
        w_nsl = 5'd1;
        for (int i = 0; i < 16; i++) begin
            if (r_max[i]) w_nsl = 5'(i + 1);
        end
        if (w_nsl > 5'(MAX_SLICES)) w_nsl = 5'(MAX_SLICES);
    end

    logic [2:0] w_status;
    always_comb begin
        if (w_key < 0) w_status = ST_NEG_KEY;
        else if (w_key >= 32'(ROW_COUNT)) w_status = ST_KEY_RANGE;
        else if (w_val < 0) w_status = ST_NEG_VAL;
        else if (w_val < $signed({16'd0, r_min}) || w_val > $signed({16'd0, r_max}))
            w_status = ST_VAL_RANGE;
        else w_status = ST_OK;
    end

    // Greater start: number of trailing ones in the code.
    logic [5:0] w_start;
    logic signed [31:0] w_code;
    always_comb begin
        w_code = (w_op == OP_GEQ) ? w_val - 32'sd1 : w_val;
        w_start = 6'd31;
        for (int i = 30; i >= 0; i--) begin
            if (!w_code[i]) w_start = 6'(i);
        end
    end

    wire w_in_acc  = s_axis_tvalid && s_axis_tready;
    wire w_out_acc = m_axis_tvalid && m_axis_tready;
    wire w_is_ex   = (r_slice == SW'(MAX_SLICES));
    wire w_cbit    = r_code[5'(r_slice)];

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;
    assign m_axis_tlast  = r_last;

    always_comb begin
        w_we = 1'b0;
        w_wdata = w_rdata;
        w_addr = AW'(r_slice) * AW'(WORDS) + AW'(r_word);
        if (r_state == S_CLEAR) begin
            w_we = 1'b1;
            w_wdata = '0;
            w_addr = r_clr[AW-1:0];
        end else if (r_state == S_APPWR) begin
            w_we = r_aok;
            w_wdata = w_rdata | (64'd1 << r_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_min <= 16'd0;
            r_max <= 16'hFFFF;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_MIN) r_min <= i_cfg_data;
                else r_max <= i_cfg_data;
            end
            // The output state reloads the result register itself.
            if (w_out_acc && r_state != S_OUT) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CNTW'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_nsl <= w_nsl;
                        r_bit <= w_key[5:0];
                        if (w_op == OP_APPEND) begin
                            r_op <= OP_APPEND;
                            r_aok <= (w_status == ST_OK);
                            r_word <= WW'(w_key >>> 6);
                            r_slice <= '0;
                            r_code <= w_val;
                            r_out <= {1'b0, w_status, 68'd0};
                            r_state <= S_APPRD;
                        end else if (w_op <= OP_NOTNULL) begin
                            r_word <= '0;
                            r_code <= w_code;
                            r_started <= 1'b0;
                            r_slice <= SW'(MAX_SLICES);
                            r_state <= S_RD;
                            if (w_op == OP_NOTNULL
                                || (w_op == OP_GREATER && w_val[31])
                                || (w_op == OP_GEQ && w_val <= 32'sd0)) begin
                                r_op <= OP_NOTNULL;
                                r_empty <= 1'b0;
                            end else if ((w_op == OP_GREATER || w_op == OP_GEQ)
                                         && w_start >= 6'(w_nsl)) begin
                                r_op <= t_opcode'(w_op);
                                r_empty <= 1'b1;
                            end else begin
                                r_op <= t_opcode'(w_op);
                                r_empty <= 1'b0;
                            end
                        end
                    end
                end
                S_APPRD: begin
                    // Skip slices whose value bit is clear.
                    if (w_is_ex || (w_cbit && r_slice < SW'(MAX_SLICES)
                                    && r_slice < SW'(31)))
                        r_state <= S_APPWR;
                    else r_slice <= r_slice + 1'b1;
                end
                S_APPWR: begin
                    if (w_is_ex) begin
                        r_ovalid <= 1'b1;
                        r_last <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_slice <= r_slice + 1'b1;
                        r_state <= S_APPRD;
                    end
                end
                S_RD: r_state <= S_USE;
                S_USE: begin
                    // Existence word first, then slices 0 up to count-1.
                    if (w_is_ex) begin
                        r_acc <= w_rdata;
                        r_exist <= w_rdata;
                        r_slice <= '0;
                        if (r_op == OP_NOTNULL || r_empty
                            || r_nsl == 5'd0) r_state <= S_OUT;
                        else r_state <= S_RD;
                    end else begin
                        if (r_op == OP_EQUAL) begin
                            r_acc <= w_cbit ? (r_acc & w_rdata) : (r_acc & ~w_rdata);
                        end else if (!r_started) begin
                            if (!w_cbit) begin
                                r_started <= 1'b1;
                                r_acc <= r_acc & w_rdata;
                            end
                        end else begin
                            // Rows brought in by an OR are kept to existing rows.
                            r_acc <= w_cbit ? (r_acc & w_rdata)
                                            : (r_acc | (w_rdata & r_exist));
                        end
                        if (5'(r_slice) + 5'd1 == r_nsl) r_state <= S_OUT;
                        else begin
                            r_slice <= r_slice + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || w_out_acc) begin
                        r_out <= {4'd0, 4'(r_word),
                                  r_empty ? 64'd0 : r_acc};
                        r_last <= (r_word == WW'(WORDS - 1));
                        r_ovalid <= 1'b1;
                        r_started <= 1'b0;
                        r_slice <= SW'(MAX_SLICES);
                        if (r_word == WW'(WORDS - 1)) r_state <= S_IDLE;
                        else begin
                            r_word <= r_word + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("request taken while busy");
    a_append_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_ovalid) && $past(r_state) == S_APPWR) |-> r_last)
        else $error("append result without last");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready) |=> r_ovalid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

FILE: tb/tb_bit_sliced_index_query.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-sliced index query testbench
// Drives appends and queries with random idling, predicts every bitmap word
// and status from a local copy of the index, and compares each response.
// ----------------------------------------------------------------------------
module tb_bit_sliced_index_query;
    import bsi_pkg::*;

    localparam int ROWS   = 1024;
    localparam int SLICES = 16;
    localparam int WORDS  = ROWS / 64;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct packed {
        logic [63:0] row_bits;
        logic [3:0]  word_index;
        logic        last;
        logic [2:0]  status;
    } t_resp;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] key;
        logic [31:0] val;
        logic        has_expect;
        logic [2:0]  exp_status;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    logic [63:0] exist_bits [WORDS];
    logic [63:0] slice_bits [SLICES][WORDS];
    logic [15:0] min_val;
    logic [15:0] max_val;
    t_resp       pending_resp [$];
    int          fail_count;
    int          idle_cycles;
    bit          no_idle;
    bit          hold_off;
    t_row        directed [$];

    bit_sliced_index_query #(.ROW_COUNT(ROWS), .MAX_SLICES(SLICES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int slice_total();
        int n;
        n = 0;
        for (int b = 0; b < 16; b++)
            if (max_val[b]) n = b + 1;
        if (n < 1) n = 1;
        if (n > SLICES) n = SLICES;
        return n;
    endfunction

    function automatic logic [63:0] equal_word(logic [31:0] code, int w, int n);
        logic [63:0] r;
        r = exist_bits[w];
        for (int i = 0; i < n; i++)
            r = code[i] ? (r & slice_bits[i][w]) : (r & ~slice_bits[i][w]);
        return r;
    endfunction

    function automatic logic [63:0] greater_word(logic [31:0] code, int w, int n);
        int first;
        logic [63:0] r;
        if (code[31]) return exist_bits[w];
        first = 0;
        while (first < 31 && code[first]) first++;
        if (first >= n) return '0;
        r = slice_bits[first][w];
        for (int i = first + 1; i < n; i++)
            r = code[i] ? (r & slice_bits[i][w]) : (r | slice_bits[i][w]);
        return r & exist_bits[w];
    endfunction

    // Updates the local index and queues the responses one request causes.
    task automatic predict_request(logic [2:0] op, logic [31:0] key, logic [31:0] val);
        t_resp r;
        logic [2:0] st;
        int n;
        n = slice_total();
        if (op == OP_APPEND) begin
            if (key[31]) st = ST_NEG_KEY;
            else if (key >= ROWS) st = ST_KEY_RANGE;
            else if (val[31]) st = ST_NEG_VAL;
            else if (val < min_val || val > max_val) st = ST_VAL_RANGE;
            else st = ST_OK;
            if (st == ST_OK) begin
                for (int i = 0; i < SLICES; i++)
                    if (val[i]) slice_bits[i][key / 64][key % 64] = 1'b1;
                exist_bits[key / 64][key % 64] = 1'b1;
            end
            r = '{64'd0, 4'd0, 1'b1, st};
            pending_resp.push_back(r);
        end else if (op <= OP_NOTNULL) begin
            for (int w = 0; w < WORDS; w++) begin
                case (op)
                    OP_EQUAL: r.row_bits = equal_word(val, w, n);
                    OP_GREATER: r.row_bits = greater_word(val, w, n);
                    OP_GEQ: r.row_bits = ($signed(val) <= 0) ? exist_bits[w]
                                                             : greater_word(val - 1, w, n);
                    default: r.row_bits = exist_bits[w];
                endcase
                r.word_index = w[3:0];
                r.last = (w == WORDS - 1);
                r.status = ST_OK;
                pending_resp.push_back(r);
            end
        end
    endtask

    task automatic report_mismatch(string what, logic [71:0] got, logic [71:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Response side: random stalls, a long hold-off on request, and checking.
    initial begin
        int burst;
        t_resp want;
        m_axis_tready = 1'b0;
        burst = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_resp.size() == 0) begin
                    report_mismatch("unexpected response", m_axis_tdata, '0);
                end else begin
                    want = pending_resp.pop_front();
                    if (m_axis_tdata[63:0] !== want.row_bits)
                        report_mismatch("row_bits", m_axis_tdata[63:0], want.row_bits);
                    if (m_axis_tdata[67:64] !== want.word_index)
                        report_mismatch("word_index", m_axis_tdata[67:64], want.word_index);
                    if (m_axis_tdata[70:68] !== want.status)
                        report_mismatch("status", m_axis_tdata[70:68], want.status);
                    if (m_axis_tdata[71] !== 1'b0)
                        report_mismatch("fill bit", m_axis_tdata[71], 1'b0);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last", m_axis_tlast, want.last);
                end
            end
            if (hold_off) begin
                m_axis_tready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                m_axis_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no handshake anywhere.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_request(logic [2:0] op, logic [31:0] key, logic [31:0] val);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, val, key, op};
        @(posedge i_clk iff s_axis_tready);
        predict_request(op, key, val);
    endtask

    task automatic drain_responses();
        s_axis_tvalid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
        // Ignored opcodes may still be in flight with no response.
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_register(logic idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk iff o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_MIN) min_val = data;
        else max_val = data;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return {16'd0, 16'($urandom())};
            2: return $urandom_range(0, 40);
            default: return {16'd0, 16'($urandom_range(0, max_val))};
        endcase
    endfunction

    task automatic random_phase(int count);
        logic [2:0]  op;
        logic [31:0] key;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) < 7) op = OP_APPEND;
            else op = 3'($urandom_range(1, 7));
            case ($urandom_range(0, 7))
                0: key = $urandom();
                1: key = $urandom_range(ROWS, ROWS + 3);
                default: key = $urandom_range(0, ROWS - 1);
            endcase
            send_request(op, key, random_value());
        end
    endtask

    initial begin
        t_row row;
        int unsigned pick;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        fail_count = 0;
        no_idle = 1'b0;
        hold_off = 1'b0;
        min_val = 16'd0;
        max_val = 16'hFFFF;
        for (int w = 0; w < WORDS; w++) begin
            exist_bits[w] = '0;
            for (int s = 0; s < SLICES; s++) slice_bits[s][w] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows; a status is typed in where it is plain from the checks.
        directed = '{
            '{OP_NOTNULL, 32'd0, 32'd0, 1'b0, ST_OK},
            '{OP_APPEND, 32'h8000_0000, 32'd5, 1'b1, ST_NEG_KEY},
            '{OP_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_NEG_KEY},
            '{OP_APPEND, 32'd1024, 32'd5, 1'b1, ST_KEY_RANGE},
            '{OP_APPEND, 32'h7FFF_FFFF, 32'd5, 1'b1, ST_KEY_RANGE},
            '{OP_APPEND, 32'd3, 32'h8000_0000, 1'b1, ST_NEG_VAL},
            '{OP_APPEND, 32'd3, 32'h0001_0000, 1'b1, ST_VAL_RANGE},
            '{OP_APPEND, 32'd3, 32'h7FFF_FFFF, 1'b1, ST_VAL_RANGE},
            '{OP_APPEND, 32'd0, 32'd0, 1'b1, ST_OK},
            '{OP_APPEND, 32'd1023, 32'hFFFF, 1'b1, ST_OK},
            '{OP_APPEND, 32'd64, 32'h5555, 1'b1, ST_OK},
            '{OP_APPEND, 32'd65, 32'hAAAA, 1'b1, ST_OK},
            '{OP_APPEND, 32'd500, 32'd7, 1'b1, ST_OK},
            '{OP_EQUAL, 32'd9, 32'd7, 1'b0, ST_OK},
            '{OP_EQUAL, 32'd0, 32'h0001_0007, 1'b0, ST_OK},
            '{OP_GREATER, 32'd0, 32'd6, 1'b0, ST_OK},
            '{OP_GREATER, 32'd0, 32'hFFFF_FFFF, 1'b0, ST_OK},
            '{OP_GREATER, 32'd0, 32'h0000_FFFF, 1'b0, ST_OK},
            '{OP_GEQ, 32'd0, 32'd0, 1'b0, ST_OK},
            '{OP_GEQ, 32'd0, 32'h8000_0000, 1'b0, ST_OK},
            '{OP_GEQ, 32'd0, 32'd7, 1'b0, ST_OK},
            '{OP_NOTNULL, 32'd0, 32'd0, 1'b0, ST_OK},
            '{3'd5, 32'd0, 32'd0, 1'b0, ST_OK},
            '{3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, ST_OK}
        };
        foreach (directed[k]) begin
            row = directed[k];
            send_request(row.op, row.key, row.val);
            // The predictor queued the append status last; cross-check the table.
            if (row.has_expect && pending_resp[$].status !== row.exp_status)
                report_mismatch("table status", pending_resp[$].status, row.exp_status);
        end
        drain_responses();

        // Narrow range and few slices, with a long receiver hold-off.
        write_register(CFG_MIN, 16'd3);
        write_register(CFG_MAX, 16'd12);
        hold_off = 1'b1;
        fork
            random_phase(30);
            begin
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join
        drain_responses();

        // Minimum above maximum rejects every append; one slice only.
        write_register(CFG_MIN, 16'hFFFF);
        write_register(CFG_MAX, 16'd0);
        random_phase(20);
        drain_responses();

        write_register(CFG_MIN, 16'd0);
        write_register(CFG_MAX, 16'd1);
        random_phase(40);
        drain_responses();

        write_register(CFG_MIN, 16'($urandom_range(0, 100)));
        write_register(CFG_MAX, 16'($urandom_range(200, 4000)));
        random_phase(45);
        drain_responses();

        write_register(CFG_MIN, 16'd0);
        write_register(CFG_MAX, 16'hFFFF);
        random_phase(40);
        no_idle = 1'b1;
        pick = $urandom_range(30, 40);
        random_phase(pick);
        drain_responses();

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

FILE: bit_sliced_index_query.f
src/bsi_pkg.sv
src/bsi_ram.sv
src/bit_sliced_index_query.sv
tb/tb_bit_sliced_index_query.sv
